// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

// ===== rtl/tmgq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmgq_pkg
// Types and constants shared by the tone-map / gamma / quantise block.
// ----------------------------------------------------------------------------
package tmgq_pkg;

   localparam int FRAC_BITS = 16;

   localparam logic [31:0] PEAK_RESET         = 32'(1) << FRAC_BITS;
   localparam logic [15:0] SAMPLE_LIMIT_RESET = 16'd1000;

   localparam logic [15:0] LUM_W_R   = 16'd13933;
   localparam logic [15:0] LUM_W_G   = 16'd46871;
   localparam logic [15:0] LUM_W_B   = 16'd4732;
   localparam logic [15:0] SCALE_NUM = 16'd25599;
   localparam logic [15:0] SCALE_DEN = 16'd100;
   // 2^19 / 100 rounded up: exact floor of t / 100 for t below 25600
   localparam logic [15:0] RECIP_100 = 16'd5243;

   localparam logic [1:0]  REG_SAMPLE_LIMIT = 2'd0;
   localparam logic        OP_SCAN          = 1'b0;
   localparam logic        OP_MAP           = 1'b1;
   localparam logic [1:0]  CHAN_LAST        = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LUM_R, ST_LUM_G, ST_LUM_B, ST_LUM_UPD,
      ST_COL_CMP, ST_COL_QWAIT, ST_COL_ROOT, ST_COL_RWAIT, ST_COL_MUL,
      ST_COL_BDIV, ST_COL_STORE,
      ST_VAR_MUL, ST_VAR_DEN, ST_VAR_DIV, ST_VAR_WAIT, ST_VAR_STORE,
      ST_SMP_MUL, ST_SMP_DEN, ST_SMP_DIV, ST_SMP_WAIT, ST_SMP_STORE,
      ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      DP_NONE, DP_LOAD, DP_LUM_R, DP_LUM_G, DP_LUM_B, DP_LUM_UPD,
      DP_COL_START, DP_SQRT_START, DP_COL_MUL, DP_COL_DIV, DP_COL_STORE,
      DP_VAR_MUL, DP_VAR_DEN, DP_VAR_DIV, DP_VAR_STORE,
      DP_SMP_MUL, DP_SMP_DEN, DP_SMP_DIV, DP_SMP_STORE, DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic col_ge;
      logic div_busy;
      logic sqrt_busy;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/tmgq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmgq_div
// Restoring divider, one quotient bit per cycle, 32 or 48 bits of quotient.
// ----------------------------------------------------------------------------
module tmgq_div import tmgq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        long_mode,
   input  logic [31:0] rem0,
   input  logic [47:0] low,
   input  logic [38:0] den,
   output logic        busy,
   output logic [47:0] quo
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [38:0] rem_ff, rem_in;
   logic [47:0] low_ff, low_in;
   logic [47:0] quo_ff, quo_in;
   logic [38:0] den_ff, den_in;
   logic [39:0] rem_sh;
   logic        fits;

   always_comb begin
      rem_sh  = {rem_ff, low_ff[47]};
      fits    = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = long_mode ? 6'd48 : 6'd32;
         rem_in  = {7'd0, rem0};
         low_in  = long_mode ? low : {low[31:0], 16'd0};
         quo_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         // rem stays below den, so the difference fits the narrower register
         rem_in  = fits ? 39'(rem_sh - {1'b0, den_ff}) : rem_sh[38:0];
         low_in  = {low_ff[46:0], 1'b0};
         quo_in  = {quo_ff[46:0], fits};
         cnt_in  = cnt_ff - 6'd1;
         busy_in = cnt_ff != 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/tmgq_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmgq_sqrt
// Integer square root of a 32-bit word, one root bit per cycle.
// ----------------------------------------------------------------------------
module tmgq_sqrt import tmgq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] rad,
   output logic        busy,
   output logic [15:0] root
);

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] rem_ff, rem_in;
   logic [31:0] rad_ff, rad_in;
   logic [15:0] root_ff, root_in;
   logic [18:0] rem_sh, trial;
   logic        fits;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[31:30]};
      trial   = {1'b0, root_ff, 2'b01};
      fits    = rem_sh >= trial;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd16;
         rem_in  = '0;
         rad_in  = rad;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? 17'(rem_sh - trial) : rem_sh[16:0];
         rad_in  = {rad_ff[29:0], 2'b00};
         root_in = {root_ff[14:0], fits};
         cnt_in  = cnt_ff - 5'd1;
         busy_in = cnt_ff != 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== rtl/tmgq_dpath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// tmgq_dpath
// Item registers, shared multiplier, peak statistics, divider, square root
// and the result register.
// ----------------------------------------------------------------------------
module tmgq_dpath import tmgq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_op,
   input  logic [31:0] req_red_in,
   input  logic [31:0] req_green_in,
   input  logic [31:0] req_blue_in,
   input  logic [31:0] req_pixel_variance,
   input  logic [15:0] req_pixel_samples,
   input  logic [15:0] sample_limit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_variance_out,
   output logic [7:0]  rsp_samples_out
);

   logic        op_ff;
   logic [31:0] col_ff [3];
   logic [31:0] var_ff;
   logic [15:0] smp_ff;
   logic [31:0] peak_lum_ff, peak_lum_in;
   logic [31:0] peak_var_ff, peak_var_in;
   logic [47:0] mul_ff, mul_in;
   logic [47:0] acc_ff, acc_in;
   logic [38:0] den_ff, den_in;
   logic [7:0]  byte_ff [5];
   logic        rsp_valid_ff, rsp_valid_in;

   logic [31:0] mul_a, cur_col, lum, limit_eff;
   logic [15:0] mul_b;
   logic [47:0] lum_sum;
   logic        out_free;

   logic        div_start, div_long, div_busy;
   logic [31:0] div_rem0;
   logic [47:0] div_low, div_quo;
   logic [38:0] div_den;
   logic        sqrt_start, sqrt_busy;
   logic [15:0] sqrt_root;
   logic [7:0]  div_sat;

   assign cur_col   = col_ff[cmd.chan];
   assign limit_eff = (sample_limit == 16'd0) ? 32'd1 : {16'd0, sample_limit};
   assign lum_sum   = acc_ff + mul_ff;
   assign lum       = lum_sum[47:16];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign div_sat   = (div_quo[47:8] != '0) ? 8'hFF : div_quo[7:0];

   // one multiplier shared by the luminance, colour, variance and sample steps
   always_comb begin
      mul_a = 32'd0;
      mul_b = 16'd0;
      case (cmd.op)
         DP_LUM_R:   begin mul_a = col_ff[0]; mul_b = LUM_W_R; end
         DP_LUM_G:   begin mul_a = col_ff[1]; mul_b = LUM_W_G; end
         DP_LUM_B:   begin mul_a = col_ff[2]; mul_b = LUM_W_B; end
         DP_COL_MUL: begin mul_a = {16'd0, sqrt_root}; mul_b = SCALE_NUM; end
         // drop the 16 fraction bits, then divide by 100 through the reciprocal
         DP_COL_DIV: begin mul_a = {17'd0, mul_ff[30:16]}; mul_b = RECIP_100; end
         DP_VAR_MUL: begin mul_a = peak_var_ff; mul_b = SCALE_DEN; end
         DP_VAR_DEN: begin mul_a = var_ff; mul_b = SCALE_NUM; end
         DP_SMP_MUL: begin mul_a = limit_eff; mul_b = SCALE_DEN; end
         DP_SMP_DEN: begin mul_a = {16'd0, smp_ff}; mul_b = SCALE_NUM; end
         default:    begin mul_a = 32'd0; mul_b = 16'd0; end
      endcase
      mul_in = mul_a * mul_b;
   end

   always_comb begin
      div_start  = 1'b0;
      div_long   = 1'b0;
      div_rem0   = 32'd0;
      div_low    = mul_ff;
      div_den    = den_ff;
      sqrt_start = 1'b0;
      acc_in     = acc_ff;
      den_in     = den_ff;
      peak_lum_in = peak_lum_ff;
      peak_var_in = peak_var_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (cmd.op)
         DP_LUM_G:   acc_in = mul_ff;
         DP_LUM_B:   acc_in = lum_sum;
         DP_LUM_UPD: begin
            if (lum > peak_lum_ff) peak_lum_in = lum;
            if (var_ff > peak_var_ff) peak_var_in = var_ff;
         end
         DP_COL_START: begin
            div_start = cur_col < peak_lum_ff;
            div_rem0  = cur_col;
            div_low   = 48'd0;
            div_den   = {7'd0, peak_lum_ff};
         end
         DP_SQRT_START: sqrt_start = 1'b1;
         DP_VAR_DEN, DP_SMP_DEN: den_in = mul_ff[38:0];
         DP_VAR_DIV: begin
            div_start = 1'b1;
            div_long  = 1'b1;
         end
         DP_SMP_DIV: div_start = 1'b1;
         DP_OUT:     rsp_valid_in = 1'b1;
         default:    ;
      endcase
   end

   tmgq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .long_mode (div_long),
      .rem0      (div_rem0),
      .low       (div_low),
      .den       (div_den),
      .busy      (div_busy),
      .quo       (div_quo)
   );

   tmgq_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .rad   (div_quo[31:0]),
      .busy  (sqrt_busy),
      .root  (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_lum_ff  <= PEAK_RESET;
         peak_var_ff  <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         peak_lum_ff  <= peak_lum_in;
         peak_var_ff  <= peak_var_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mul_ff <= mul_in;
      acc_ff <= acc_in;
      den_ff <= den_in;
      if (cmd.op == DP_LOAD) begin
         op_ff     <= req_op;
         col_ff[0] <= req_red_in;
         col_ff[1] <= req_green_in;
         col_ff[2] <= req_blue_in;
         var_ff    <= req_pixel_variance;
         smp_ff    <= req_pixel_samples;
      end
      if (cmd.op == DP_COL_START && cur_col >= peak_lum_ff)
         byte_ff[{1'b0, cmd.chan}] <= 8'hFF;
      if (cmd.op == DP_COL_STORE) byte_ff[{1'b0, cmd.chan}] <= mul_ff[26:19];
      if (cmd.op == DP_VAR_STORE) byte_ff[3] <= (peak_var_ff == 32'd0) ? 8'd0 : div_sat;
      if (cmd.op == DP_SMP_STORE) byte_ff[4] <= div_sat;
      if (cmd.op == DP_OUT) begin
         rsp_red_out      <= byte_ff[0];
         rsp_green_out    <= byte_ff[1];
         rsp_blue_out     <= byte_ff[2];
         rsp_variance_out <= byte_ff[3];
         rsp_samples_out  <= byte_ff[4];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign status.op        = op_ff;
   assign status.col_ge    = cur_col >= peak_lum_ff;
   assign status.div_busy  = div_busy;
   assign status.sqrt_busy = sqrt_busy;
   assign status.out_free  = out_free;

   `ASSERT_IMPLY(a_div_idle_start, clock, reset, div_start, !div_busy)
   `ASSERT_IMPLY(a_sqrt_idle_start, clock, reset, sqrt_start, !sqrt_busy)
   `ASSERT_ALWAYS(a_peak_floor, clock, reset, peak_lum_ff >= PEAK_RESET)

endmodule

// ===== rtl/tmgq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmgq_ctrl
// Sequencer that steps the datapath through a scan or a map item.
// ----------------------------------------------------------------------------
module tmgq_ctrl import tmgq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] chan_ff, chan_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      chan_in   = chan_ff;
      cmd.op    = DP_NONE;
      cmd.chan  = chan_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            chan_in   = 2'd0;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_LUM_R;
            end
         end
         ST_LUM_R: begin
            if (status.op == OP_SCAN) begin
               cmd.op   = DP_LUM_R;
               state_in = ST_LUM_G;
            end else begin
               state_in = ST_COL_CMP;
            end
         end
         ST_LUM_G:   begin cmd.op = DP_LUM_G; state_in = ST_LUM_B; end
         ST_LUM_B:   begin cmd.op = DP_LUM_B; state_in = ST_LUM_UPD; end
         ST_LUM_UPD: begin cmd.op = DP_LUM_UPD; state_in = ST_IDLE; end
         ST_COL_CMP: begin
            cmd.op = DP_COL_START;
            if (!status.col_ge) begin
               state_in = ST_COL_QWAIT;
            end else if (chan_ff == CHAN_LAST) begin
               state_in = ST_VAR_MUL;
            end else begin
               chan_in = chan_ff + 2'd1;
            end
         end
         ST_COL_QWAIT: if (!status.div_busy) state_in = ST_COL_ROOT;
         ST_COL_ROOT:  begin cmd.op = DP_SQRT_START; state_in = ST_COL_RWAIT; end
         ST_COL_RWAIT: if (!status.sqrt_busy) state_in = ST_COL_MUL;
         ST_COL_MUL:   begin cmd.op = DP_COL_MUL; state_in = ST_COL_BDIV; end
         ST_COL_BDIV:  begin cmd.op = DP_COL_DIV; state_in = ST_COL_STORE; end
         ST_COL_STORE: begin
            cmd.op = DP_COL_STORE;
            if (chan_ff == CHAN_LAST) begin
               state_in = ST_VAR_MUL;
            end else begin
               chan_in  = chan_ff + 2'd1;
               state_in = ST_COL_CMP;
            end
         end
         ST_VAR_MUL:   begin cmd.op = DP_VAR_MUL; state_in = ST_VAR_DEN; end
         ST_VAR_DEN:   begin cmd.op = DP_VAR_DEN; state_in = ST_VAR_DIV; end
         ST_VAR_DIV:   begin cmd.op = DP_VAR_DIV; state_in = ST_VAR_WAIT; end
         ST_VAR_WAIT:  if (!status.div_busy) state_in = ST_VAR_STORE;
         ST_VAR_STORE: begin cmd.op = DP_VAR_STORE; state_in = ST_SMP_MUL; end
         ST_SMP_MUL:   begin cmd.op = DP_SMP_MUL; state_in = ST_SMP_DEN; end
         ST_SMP_DEN:   begin cmd.op = DP_SMP_DEN; state_in = ST_SMP_DIV; end
         ST_SMP_DIV:   begin cmd.op = DP_SMP_DIV; state_in = ST_SMP_WAIT; end
         ST_SMP_WAIT:  if (!status.div_busy) state_in = ST_SMP_STORE;
         ST_SMP_STORE: begin cmd.op = DP_SMP_STORE; state_in = ST_OUT; end
         ST_OUT: begin
            // hold until the result register can take the word
            if (status.out_free) begin
               cmd.op   = DP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/hdr_tone_map_gamma_quantize_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_tone_map_gamma_quantize_top
// Two-pass HDR tone mapper: scan words gather peaks, map words give bytes.
// ----------------------------------------------------------------------------
// A scan word (op 0) gives no result; it updates the peak luminance and variance
// and passes through the luminance steps before the next word can be accepted.
// In a map word each colour below the peak luminance waits on a 32-bit division
// and then on the square root before its multiply and scale steps, a colour at
// or above the peak is set to 255 without a division, and the variance and
// sample bytes wait on a 48-bit and a 32-bit division. The time per map word is
// set by the shared divider and by the root unit, which yield one bit per cycle.
// The result register lets the next word be accepted while a result waits.
module hdr_tone_map_gamma_quantize_top import tmgq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_red_in,
   input  logic [31:0] req_green_in,
   input  logic [31:0] req_blue_in,
   input  logic [31:0] req_pixel_variance,
   input  logic [15:0] req_pixel_samples,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_variance_out,
   output logic [7:0]  rsp_samples_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0] sample_limit_ff, sample_limit_in;
   cmd_type     cmd;
   status_type  status;

   always_comb begin
      sample_limit_in = sample_limit_ff;
      if (psel && penable && pwrite && paddr == REG_SAMPLE_LIMIT)
         sample_limit_in = pwdata[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_limit_ff <= SAMPLE_LIMIT_RESET;
      end else begin
         sample_limit_ff <= sample_limit_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == REG_SAMPLE_LIMIT) ? {16'd0, sample_limit_ff} : 32'd0;

   tmgq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tmgq_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_red_in         (req_red_in),
      .req_green_in       (req_green_in),
      .req_blue_in        (req_blue_in),
      .req_pixel_variance (req_pixel_variance),
      .req_pixel_samples  (req_pixel_samples),
      .sample_limit       (sample_limit_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red_out        (rsp_red_out),
      .rsp_green_out      (rsp_green_out),
      .rsp_blue_out       (rsp_blue_out),
      .rsp_variance_out   (rsp_variance_out),
      .rsp_samples_out    (rsp_samples_out)
   );

endmodule

// ===== dv/tb_hdr_tone_map_gamma_quantize_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdr_tone_map_gamma_quantize_top
// Self-checking bench for the two-pass HDR tone mapper. A local model tracks
// the peak luminance and variance and predicts every map result. Scan and map
// words are sent with random gaps and random result back-pressure. The sample
// limit register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_hdr_tone_map_gamma_quantize_top;
   import tmgq_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] variance;
      logic [7:0] samples;
   } pixel_bytes_type;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_SCAN;
   logic [31:0] req_red_in = '0;
   logic [31:0] req_green_in = '0;
   logic [31:0] req_blue_in = '0;
   logic [31:0] req_pixel_variance = '0;
   logic [15:0] req_pixel_samples = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red_out, rsp_green_out, rsp_blue_out;
   logic [7:0]  rsp_variance_out, rsp_samples_out;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // model state
   logic [31:0] mdl_peak_lum;
   logic [31:0] mdl_peak_var;
   logic [15:0] mdl_sample_limit;

   pixel_bytes_type pending_pixels[$];
   bit  idle_on = 1'b1;
   int  fail_count = 0;
   int  scan_count = 0;
   int  map_count = 0;
   int  result_count = 0;
   int  quiet_cycles = 0;
   int  stall_left = 0;

   hdr_tone_map_gamma_quantize_top dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[31:0];
   endfunction

   function automatic logic [7:0] gamma_byte(logic [31:0] c);
      logic [63:0] q;
      logic [63:0] s;
      if (c >= mdl_peak_lum) return 8'd255;
      q = {c, 32'd0} / {32'd0, mdl_peak_lum};
      s = {32'd0, int_sqrt(q)};
      return 8'((s * 64'd25599) / 64'd6553600);
   endfunction

   function automatic logic [7:0] scale_byte(logic [63:0] num, logic [63:0] den);
      logic [63:0] r;
      r = (num * 64'd25599) / (64'd100 * den);
      return (r > 255) ? 8'd255 : r[7:0];
   endfunction

   // accept-time model step: scans move the peaks, maps queue their bytes
   task automatic predict_word(logic op, logic [31:0] r, logic [31:0] g, logic [31:0] b,
                               logic [31:0] v, logic [15:0] n);
      logic [63:0] acc;
      pixel_bytes_type px;
      if (op == OP_SCAN) begin
         acc = r * 64'd13933 + g * 64'd46871 + b * 64'd4732;
         if (acc[47:16] > mdl_peak_lum) mdl_peak_lum = acc[47:16];
         if (v > mdl_peak_var) mdl_peak_var = v;
         scan_count++;
      end else begin
         px.red      = gamma_byte(r);
         px.green    = gamma_byte(g);
         px.blue     = gamma_byte(b);
         px.variance = (mdl_peak_var == 0) ? 8'd0 : scale_byte(v, mdl_peak_var);
         px.samples  = scale_byte(n, (mdl_sample_limit == 0) ? 64'd1 : mdl_sample_limit);
         pending_pixels.push_back(px);
         map_count++;
      end
   endtask

   task automatic send_word(logic op, logic [31:0] r, logic [31:0] g, logic [31:0] b,
                            logic [31:0] v, logic [15:0] n);
      int gap;
      if (idle_on && ($urandom_range(0, 3) == 0)) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_red_in         <= r;
      req_green_in       <= g;
      req_blue_in        <= b;
      req_pixel_variance <= v;
      req_pixel_samples  <= n;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(op, r, g, b, v, n);
   endtask

   task automatic drain_pixels();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      // a trailing scan word may still be in flight
      repeat (12) @(posedge clock);
   endtask

   task automatic write_sample_limit(logic [15:0] value);
      drain_pixels();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_SAMPLE_LIMIT;
      pwdata  <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      mdl_sample_limit = value;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_level(int min_shift);
      return $urandom >> $urandom_range(min_shift, 31);
   endfunction

   task automatic send_random(logic op, int min_shift);
      send_word(op, rand_level(min_shift), rand_level(min_shift), rand_level(min_shift),
                rand_level(0), 16'($urandom));
   endtask

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      pixel_bytes_type exp_px;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (pending_pixels.size() == 0) begin
            $error("result word with no prediction waiting");
            fail_count++;
         end else begin
            exp_px = pending_pixels.pop_front();
            if (rsp_red_out !== exp_px.red) begin
               $error("red_out expected %0d actual %0d", exp_px.red, rsp_red_out);
               fail_count++;
            end
            if (rsp_green_out !== exp_px.green) begin
               $error("green_out expected %0d actual %0d", exp_px.green, rsp_green_out);
               fail_count++;
            end
            if (rsp_blue_out !== exp_px.blue) begin
               $error("blue_out expected %0d actual %0d", exp_px.blue, rsp_blue_out);
               fail_count++;
            end
            if (rsp_variance_out !== exp_px.variance) begin
               $error("variance_out expected %0d actual %0d", exp_px.variance,
                      rsp_variance_out);
               fail_count++;
            end
            if (rsp_samples_out !== exp_px.samples) begin
               $error("samples_out expected %0d actual %0d", exp_px.samples,
                      rsp_samples_out);
               fail_count++;
            end
         end
      end
   end

   // result back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (idle_on && ($urandom_range(0, 7) == 0)) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(1, 12) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic test_map_before_scan();
      // reset peaks: luminance 1.0, variance zero
      send_word(OP_MAP, 32'd0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h1234_5678, 16'd0);
      send_word(OP_MAP, 32'h0001_0000, 32'h0000_8000, 32'd1, 32'd0, 16'd1000);
      send_word(OP_MAP, 32'h0000_4000, 32'h0000_0100, 32'h0000_C000, 32'hFFFF_FFFF,
                16'hFFFF);
   endtask

   task automatic test_scan_extremes();
      send_word(OP_SCAN, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0);
      send_word(OP_MAP, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'd7, 16'd500);
      send_word(OP_SCAN, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                16'hFFFF);
      send_word(OP_MAP, 32'h0001_0000, 32'h0002_5000, 32'h0000_0001, 32'h0000_8000,
                16'd999);
      // variance above the scanned peak saturates
      send_word(OP_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0003_0000, 32'hFFFF_FFFF,
                16'd1001);
      send_word(OP_SCAN, 32'h00FF_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                16'd3);
      send_word(OP_MAP, 32'h0080_0000, 32'h00FF_0000, 32'hFFFF_FFFF, 32'h4000_0000,
                16'd250);
   endtask

   task automatic test_sample_limit_extremes();
      logic [15:0] limits[3];
      limits = '{16'd1, 16'hFFFF, 16'd0};
      foreach (limits[i]) begin
         write_sample_limit(limits[i]);
         send_word(OP_MAP, 32'h0010_0000, 32'h0000_1000, 32'h0001_0000, 32'h2000_0000,
                   16'd0);
         send_word(OP_MAP, 32'h0000_0010, 32'h0FFF_FFFF, 32'h0000_0100, 32'h8000_0000,
                   16'd1);
         send_word(OP_MAP, 32'd12345, 32'd678, 32'd9, 32'h0800_0000, 16'hFFFF);
      end
   endtask

   task automatic test_random_frames(int words, logic [15:0] limit, int min_shift);
      int sent;
      int burst;
      write_sample_limit(limit);
      sent = 0;
      while (sent < words) begin
         // short scan run, then a run of maps over the same frame
         burst = $urandom_range(1, 6);
         repeat (burst) send_random(OP_SCAN, min_shift);
         sent += burst;
         burst = $urandom_range(1, 10);
         repeat (burst) send_random(OP_MAP, 0);
         sent += burst;
      end
   endtask

   initial begin
      mdl_peak_lum     = PEAK_RESET;
      mdl_peak_var     = '0;
      mdl_sample_limit = SAMPLE_LIMIT_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_map_before_scan();
      test_scan_extremes();
      test_sample_limit_extremes();
      // hold the sender until every result is back
      drain_pixels();
      test_random_frames(480, 16'($urandom_range(1, 65535)), 16);
      test_random_frames(480, 16'd1, 14);
      test_random_frames(480, 16'hFFFF, 12);
      idle_on = 1'b0;
      test_random_frames(480, 16'($urandom_range(1, 4000)), 0);

      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Covered %0d scan and %0d map words, %0d results checked,", scan_count,
               map_count, result_count);
      $display("over sample limits 1, 65535, 0 and random values.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
